// File: src/gb_pkg.sv
`timescale 1ns / 1ps

package gb_pkg;

  localparam int PIX_W  = 8;
  localparam int CFG_W  = 12;
  localparam int POS_W  = 11;
  localparam int PSUM_W = 10;
  localparam int SUM_W  = 12;
  localparam int IDX_W  = 1;

  localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] SIZE_RESET = 12'd2048;
  localparam logic [CFG_W-1:0] SIZE_MIN   = 12'd3;

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    pix_t top;
    pix_t mid;
    pix_t bot;
  } col_t;

endpackage

// File: src/gb_tap_cell.sv
`timescale 1ns / 1ps

module gb_tap_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  gb_pkg::col_t              d,
  output gb_pkg::col_t              q,
  output logic [gb_pkg::PSUM_W-1:0] psum
);

  gb_pkg::col_t              col_r;
  logic [gb_pkg::PSUM_W-1:0] psum_r;
  logic [gb_pkg::PSUM_W-1:0] psum_nxt;

  assign psum_nxt = {2'b00, d.top} + {1'b0, d.mid, 1'b0} + {2'b00, d.bot};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      psum_r <= '0;
    end else if (en) begin
      col_r  <= d;
      psum_r <= psum_nxt;
    end
  end

  assign q    = col_r;
  assign psum = psum_r;

endmodule

// File: src/gb_line_buf.sv
`timescale 1ns / 1ps

module gb_line_buf #(
  parameter int DEPTH  = 2048,
  parameter int ADDR_W = 11
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         rd_en,
  input  logic [ADDR_W-1:0]            rd_addr,
  input  logic                         wr_en,
  input  logic [ADDR_W-1:0]            wr_addr,
  input  logic [2*gb_pkg::PIX_W-1:0]   wr_data,
  output logic [2*gb_pkg::PIX_W-1:0]   rd_data
);

  logic [2*gb_pkg::PIX_W-1:0] mem [DEPTH];
  logic [2*gb_pkg::PIX_W-1:0] rdata_r;
  logic [2*gb_pkg::PIX_W-1:0] byp_data_r;
  logic                       byp_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r    <= mem[rd_addr];
      byp_data_r <= wr_data;
    end
  end

  // A read that meets a write to the same entry on the same edge takes the new word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_r <= 1'b0;
    end else if (rd_en) begin
      byp_r <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_data = byp_r ? byp_data_r : rdata_r;

endmodule

// File: src/gaussian_blur_3x3.sv
`timescale 1ns / 1ps
// Results pass the stage-1, stage-2 and output registers in turn; out_tready can stall them.
// Throughput: one pixel per clock if not stalled; line buffer: one read and one write per cycle.
// Border pixels give no result word; the window is a chain of three column cells.
// Reset (synchronous, rst_n low) clears counters, window and pipeline valids and sets both
// sizes to 2048; the line buffer is not cleared, so no clearing pass is needed.

module gaussian_blur_3x3 #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [7:0]                 in_tdata,   // [7:0] pixel
  input  logic                       in_tuser,   // [0] start_of_frame
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [31:0]                out_tdata,  // [7:0] blurred, [18:8] out_row, [29:19] out_col
  output logic                       out_tlast,  // last_pixel
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [gb_pkg::IDX_W-1:0]   cfg_index,
  input  logic [gb_pkg::CFG_W-1:0]   cfg_data
);

  localparam int CW_W = (MAX_WIDTH  > 2) ? $clog2(MAX_WIDTH)  : 1;
  localparam int RW_W = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
  localparam int EW_A = (CW_W + 1 > gb_pkg::CFG_W) ? CW_W + 1 : gb_pkg::CFG_W;
  localparam int EW_B = (RW_W + 1 > gb_pkg::CFG_W) ? RW_W + 1 : gb_pkg::CFG_W;
  localparam int EW   = (EW_A > EW_B) ? EW_A : EW_B;
  localparam int PW   = gb_pkg::PIX_W;
  localparam int OW   = gb_pkg::POS_W;

  logic [gb_pkg::CFG_W-1:0] width_r;
  logic [gb_pkg::CFG_W-1:0] height_r;
  logic [EW-1:0]            w_eff;
  logic [EW-1:0]            h_eff;
  logic [EW-1:0]            width_x;
  logic [EW-1:0]            height_x;

  logic [CW_W-1:0] col_r;
  logic [RW_W-1:0] row_r;
  logic [CW_W-1:0] col_nxt;
  logic [RW_W-1:0] row_nxt;
  logic [CW_W-1:0] c_cur;
  logic [RW_W-1:0] r_cur;
  logic [EW-1:0]   c_inc;
  logic [EW-1:0]   r_inc;
  logic            restart;
  logic            col_end;
  logic            row_end;
  logic            produced;
  logic [CW_W-1:0] c_m1;
  logic [RW_W-1:0] r_m1;
  logic [CW_W+OW-1:0] c_m1_x;
  logic [RW_W+OW-1:0] r_m1_x;

  logic            in_fire;
  logic            s1_v_r;
  logic            s1_adv;
  logic [CW_W-1:0] s1_c_r;
  gb_pkg::pix_t    s1_px_r;
  logic            s1_prod_r;
  logic            s1_last_r;
  logic [OW-1:0]   s1_orow_r;
  logic [OW-1:0]   s1_ocol_r;

  logic            s2_v_r;
  logic            s2_adv;
  logic            s2_free;
  logic            s2_last_r;
  logic [OW-1:0]   s2_orow_r;
  logic [OW-1:0]   s2_ocol_r;

  logic            out_v_r;
  logic            out_free;
  gb_pkg::pix_t    out_blur_r;
  logic [OW-1:0]   out_orow_r;
  logic [OW-1:0]   out_ocol_r;
  logic            out_last_r;

  logic [2*PW-1:0]          lb_rdata;
  gb_pkg::col_t             new_col;
  gb_pkg::col_t             chain [4];
  logic [gb_pkg::PSUM_W-1:0] psum [3];
  logic [gb_pkg::SUM_W-1:0] sum;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= gb_pkg::SIZE_RESET;
      height_r <= gb_pkg::SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        gb_pkg::REG_IMAGE_WIDTH:  width_r  <= cfg_data;
        gb_pkg::REG_IMAGE_HEIGHT: height_r <= cfg_data;
      endcase
    end
  end

  assign width_x  = EW'(width_r);
  assign height_x = EW'(height_r);

  always_comb begin
    if (width_x < EW'(gb_pkg::SIZE_MIN)) begin
      w_eff = EW'(gb_pkg::SIZE_MIN);
    end else if (width_x > EW'(MAX_WIDTH)) begin
      w_eff = EW'(MAX_WIDTH);
    end else begin
      w_eff = width_x;
    end
    if (height_x < EW'(gb_pkg::SIZE_MIN)) begin
      h_eff = EW'(gb_pkg::SIZE_MIN);
    end else if (height_x > EW'(MAX_HEIGHT)) begin
      h_eff = EW'(MAX_HEIGHT);
    end else begin
      h_eff = height_x;
    end
  end

  assign in_fire = in_tvalid && in_tready;

  always_comb begin
    restart  = in_tuser || (EW'(col_r) >= w_eff) || (EW'(row_r) >= h_eff);
    c_cur    = restart ? '0 : col_r;
    r_cur    = restart ? '0 : row_r;
    c_inc    = EW'(c_cur) + EW'(1);
    r_inc    = EW'(r_cur) + EW'(1);
    col_end  = c_inc >= w_eff;
    row_end  = r_inc >= h_eff;
    produced = (EW'(c_cur) >= EW'(2)) && (EW'(r_cur) >= EW'(2));
    c_m1     = c_cur - CW_W'(1);
    r_m1     = r_cur - RW_W'(1);
    c_m1_x   = {{OW{1'b0}}, c_m1};
    r_m1_x   = {{OW{1'b0}}, r_m1};
    if (col_end) begin
      col_nxt = '0;
      row_nxt = row_end ? '0 : r_inc[RW_W-1:0];
    end else begin
      col_nxt = c_inc[CW_W-1:0];
      row_nxt = r_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_fire) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  assign out_free  = !out_v_r || out_tready;
  assign s2_adv    = s2_v_r && out_free;
  assign s2_free   = !s2_v_r || s2_adv;
  assign s1_adv    = s1_v_r && s2_free;
  assign in_tready = !s1_v_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_v_r <= 1'b1;
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end
      if (s1_adv) begin
        s2_v_r <= s1_prod_r;
      end else if (s2_adv) begin
        s2_v_r <= 1'b0;
      end
      if (s2_adv) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_c_r    <= c_cur;
      s1_px_r   <= in_tdata[PW-1:0];
      s1_prod_r <= produced;
      s1_last_r <= col_end && row_end;
      s1_orow_r <= r_m1_x[OW-1:0];
      s1_ocol_r <= c_m1_x[OW-1:0];
    end
    if (s1_adv) begin
      s2_last_r <= s1_last_r;
      s2_orow_r <= s1_orow_r;
      s2_ocol_r <= s1_ocol_r;
    end
    if (s2_adv) begin
      out_blur_r <= sum[gb_pkg::SUM_W-1:4];
      out_orow_r <= s2_orow_r;
      out_ocol_r <= s2_ocol_r;
      out_last_r <= s2_last_r;
    end
  end

  gb_line_buf #(
    .DEPTH  (MAX_WIDTH),
    .ADDR_W (CW_W)
  ) u_line_buf (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_fire),
    .rd_addr (c_cur),
    .wr_en   (s1_adv),
    .wr_addr (s1_c_r),
    .wr_data ({s1_px_r, lb_rdata[2*PW-1:PW]}),
    .rd_data (lb_rdata)
  );

  assign new_col.top = lb_rdata[PW-1:0];
  assign new_col.mid = lb_rdata[2*PW-1:PW];
  assign new_col.bot = s1_px_r;
  assign chain[3]    = new_col;

  for (genvar i = 0; i < 3; i++) begin : g_win
    gb_tap_cell u_tap (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (s1_adv),
      .d     (chain[i+1]),
      .q     (chain[i]),
      .psum  (psum[i])
    );
  end

  assign sum = {2'b00, psum[0]} + {1'b0, psum[1], 1'b0} + {2'b00, psum[2]};

  assign out_tvalid = out_v_r;
  assign out_tdata  = {2'b00, out_ocol_r, out_orow_r, out_blur_r};
  assign out_tlast  = out_last_r;

endmodule
